[sv/ofsl_pkg.sv]
// ----------------------------------------------------------------------------
// ofsl_pkg
// shared codes, header words and result type for the object file loader
// ----------------------------------------------------------------------------
package ofsl_pkg;

    // request operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // parse phases
    localparam logic [2:0] PH_HDR_HI  = 3'd0;
    localparam logic [2:0] PH_HDR_LO  = 3'd1;
    localparam logic [2:0] PH_ADDR_HI = 3'd2;
    localparam logic [2:0] PH_ADDR_LO = 3'd3;
    localparam logic [2:0] PH_CNT_HI  = 3'd4;
    localparam logic [2:0] PH_CNT_LO  = 3'd5;
    localparam logic [2:0] PH_BODY_HI = 3'd6;
    localparam logic [2:0] PH_BODY_LO = 3'd7;

    // record types
    localparam logic [1:0] RT_WORDS  = 2'd0;
    localparam logic [1:0] RT_SYMBOL = 2'd1;
    localparam logic [1:0] RT_NAME   = 2'd2;
    localparam logic [1:0] RT_LINE   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_WRITE     = 2'd0;
    localparam logic [1:0] KIND_OK        = 2'd1;
    localparam logic [1:0] KIND_FORMAT    = 2'd2;
    localparam logic [1:0] KIND_TRUNCATED = 2'd3;

    // header words
    localparam logic [15:0] HDR_CODE   = 16'hCADE;
    localparam logic [15:0] HDR_DATA   = 16'hDADA;
    localparam logic [15:0] HDR_SYMBOL = 16'hC3B7;
    localparam logic [15:0] HDR_NAME   = 16'hF17E;
    localparam logic [15:0] HDR_LINE   = 16'h715E;

    // a line-number record skips three words
    localparam logic [15:0] LINE_SKIP_BYTES = 16'd6;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [15:0] data;
    } t_result;

endpackage

[sv/object_file_stream_loader_top.sv]
// ----------------------------------------------------------------------------
// object_file_stream_loader_top
// byte-stream object file loader: turns code/data records into memory writes
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_operation, i_data_byte
//  out     | source    | o_out_valid / i_out_stall | o_kind, o_write_address, o_write_data
//
//  one request per cycle sustained while out does not stall; a request passes through
//  the input register, then the parse update into the result register
//  synchronous active-low reset clears the parse state and both valid flags
//  a request leaves the input register only when the result register is free
//  or being drained, so a stall on out while the result register is full backs up into o_in_stall
//  an end-of-file request reports the outcome and returns the parser to idle
// ----------------------------------------------------------------------------
module object_file_stream_loader_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_write_address,
    output logic [15:0] o_write_data
);

    // input register
    logic        r_in_valid;
    logic        r_in_op;
    logic [7:0]  r_in_byte;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [15:0] r_out_addr;
    logic [15:0] r_out_data;

    ofsl_pkg::t_result core_result;

    logic out_free;
    logic advance;
    logic in_take;

    // result slot can take a new entry when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    // held request moves through the parser into the result register
    assign advance  = r_in_valid && out_free;
    // input register is free when empty or emptying
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op   <= i_operation;
            r_in_byte <= i_data_byte;
        end
    end

    // parse state and per-request update
    ofsl_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_operation (r_in_op),
        .i_data_byte (r_in_byte),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= core_result.valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_result.valid) begin
            r_out_kind <= core_result.kind;
            r_out_addr <= core_result.addr;
            r_out_data <= core_result.data;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_write_address = r_out_addr;
    assign o_write_data    = r_out_data;

endmodule

[sv/ofsl_core.sv]
// ----------------------------------------------------------------------------
// ofsl_core
// parse state registers and the per-request state update
// ----------------------------------------------------------------------------
module ofsl_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_operation,
    input  logic [7:0]          i_data_byte,
    output ofsl_pkg::t_result   o_result
);

    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_rtype, n_rtype;
    logic [7:0]  r_held,  n_held;
    logic [15:0] r_addr,  n_addr;
    logic [15:0] r_count, n_count;
    logic        r_err,   n_err;

    logic [15:0] word;
    logic [15:0] count_dec;

    assign word      = {r_held, i_data_byte};
    assign count_dec = r_count - 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_rtype  = r_rtype;
        n_held   = r_held;
        n_addr   = r_addr;
        n_count  = r_count;
        n_err    = r_err;
        o_result = '0;

        if (i_operation == ofsl_pkg::OP_EOF) begin
            o_result.valid = 1'b1;
            if (r_err) begin
                o_result.kind = ofsl_pkg::KIND_FORMAT;
            end else if (r_phase != ofsl_pkg::PH_HDR_HI) begin
                o_result.kind = ofsl_pkg::KIND_TRUNCATED;
            end else begin
                o_result.kind = ofsl_pkg::KIND_OK;
            end
            n_phase = ofsl_pkg::PH_HDR_HI;
            n_rtype = ofsl_pkg::RT_WORDS;
            n_held  = '0;
            n_addr  = '0;
            n_count = '0;
            n_err   = 1'b0;
        end else if (!r_err) begin
            case (r_phase)
                ofsl_pkg::PH_HDR_HI,
                ofsl_pkg::PH_ADDR_HI,
                ofsl_pkg::PH_CNT_HI: begin
                    n_held  = i_data_byte;
                    n_phase = r_phase + 3'd1;
                end
                ofsl_pkg::PH_HDR_LO: begin
                    if (word == ofsl_pkg::HDR_CODE || word == ofsl_pkg::HDR_DATA) begin
                        n_rtype = ofsl_pkg::RT_WORDS;
                        n_phase = ofsl_pkg::PH_ADDR_HI;
                    end else if (word == ofsl_pkg::HDR_SYMBOL) begin
                        n_rtype = ofsl_pkg::RT_SYMBOL;
                        n_phase = ofsl_pkg::PH_ADDR_HI;
                    end else if (word == ofsl_pkg::HDR_NAME) begin
                        n_rtype = ofsl_pkg::RT_NAME;
                        n_phase = ofsl_pkg::PH_CNT_HI;
                    end else if (word == ofsl_pkg::HDR_LINE) begin
                        n_rtype = ofsl_pkg::RT_LINE;
                        n_count = ofsl_pkg::LINE_SKIP_BYTES;
                        n_phase = ofsl_pkg::PH_BODY_HI;
                    end else begin
                        n_err   = 1'b1;
                        n_phase = ofsl_pkg::PH_HDR_HI;
                    end
                end
                ofsl_pkg::PH_ADDR_LO: begin
                    n_addr  = word;
                    n_phase = ofsl_pkg::PH_CNT_HI;
                end
                ofsl_pkg::PH_CNT_LO: begin
                    n_count = word;
                    n_phase = (word == 16'd0) ? ofsl_pkg::PH_HDR_HI : ofsl_pkg::PH_BODY_HI;
                end
                ofsl_pkg::PH_BODY_HI: begin
                    if (r_rtype == ofsl_pkg::RT_WORDS) begin
                        n_held  = i_data_byte;
                        n_phase = ofsl_pkg::PH_BODY_LO;
                    end else begin
                        // skipped byte of a symbol, name or line record
                        n_count = count_dec;
                        if (count_dec == 16'd0) begin
                            n_phase = ofsl_pkg::PH_HDR_HI;
                        end
                    end
                end
                ofsl_pkg::PH_BODY_LO: begin
                    o_result.valid = 1'b1;
                    o_result.kind  = ofsl_pkg::KIND_WRITE;
                    o_result.addr  = r_addr;
                    o_result.data  = word;
                    n_addr  = r_addr + 16'd1;
                    n_count = count_dec;
                    n_phase = (count_dec == 16'd0) ? ofsl_pkg::PH_HDR_HI
                                                   : ofsl_pkg::PH_BODY_HI;
                end
                default: begin
                    n_phase = ofsl_pkg::PH_HDR_HI;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ofsl_pkg::PH_HDR_HI;
            r_rtype <= ofsl_pkg::RT_WORDS;
            r_held  <= '0;
            r_addr  <= '0;
            r_count <= '0;
            r_err   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_rtype <= n_rtype;
            r_held  <= n_held;
            r_addr  <= n_addr;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the object file stream loader: feeds whole object
// files byte by byte (directed corner files, then random record mixes with
// bad headers and cut-off files), predicts every memory write and end-of-file
// status, and compares them in order with what the loader emits
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [15:0] data;
} t_loader_result;

typedef struct packed {
    logic       op;
    logic [7:0] b;
} t_file_request;

// tracks the parse of the byte stream and holds the results still owed
class loader_scoreboard;
    logic [2:0]     phase;
    logic [1:0]     rec_type;
    logic [7:0]     held_byte;
    logic [15:0]    next_addr;
    logic [15:0]    remaining;
    bit             bad_format;
    t_loader_result expected_results[$];
    int             errors;
    int             checked;
    int             kind_seen[4];

    function new();
        clear_parse();
        errors  = 0;
        checked = 0;
        foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void clear_parse();
        phase      = ofsl_pkg::PH_HDR_HI;
        rec_type   = ofsl_pkg::RT_WORDS;
        held_byte  = 8'h00;
        next_addr  = 16'h0000;
        remaining  = 16'h0000;
        bad_format = 1'b0;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // advance the parse by one accepted request
    function void predict_request(logic op, logic [7:0] b);
        logic [15:0] word;
        logic [1:0]  status;
        word = {held_byte, b};
        if (op == ofsl_pkg::OP_EOF) begin
            if (bad_format)
                status = ofsl_pkg::KIND_FORMAT;
            else if (phase != ofsl_pkg::PH_HDR_HI)
                status = ofsl_pkg::KIND_TRUNCATED;
            else
                status = ofsl_pkg::KIND_OK;
            clear_parse();
            expected_results.push_back('{kind: status, addr: 16'h0, data: 16'h0});
            return;
        end
        if (bad_format)
            return;
        case (phase)
            ofsl_pkg::PH_HDR_HI, ofsl_pkg::PH_ADDR_HI, ofsl_pkg::PH_CNT_HI: begin
                held_byte = b;
                phase     = phase + 3'd1;
            end
            ofsl_pkg::PH_HDR_LO: begin
                if (word == ofsl_pkg::HDR_CODE || word == ofsl_pkg::HDR_DATA) begin
                    rec_type = ofsl_pkg::RT_WORDS;
                    phase    = ofsl_pkg::PH_ADDR_HI;
                end else if (word == ofsl_pkg::HDR_SYMBOL) begin
                    rec_type = ofsl_pkg::RT_SYMBOL;
                    phase    = ofsl_pkg::PH_ADDR_HI;
                end else if (word == ofsl_pkg::HDR_NAME) begin
                    rec_type = ofsl_pkg::RT_NAME;
                    phase    = ofsl_pkg::PH_CNT_HI;
                end else if (word == ofsl_pkg::HDR_LINE) begin
                    rec_type  = ofsl_pkg::RT_LINE;
                    remaining = ofsl_pkg::LINE_SKIP_BYTES;
                    phase     = ofsl_pkg::PH_BODY_HI;
                end else begin
                    bad_format = 1'b1;
                    phase      = ofsl_pkg::PH_HDR_HI;
                end
            end
            ofsl_pkg::PH_ADDR_LO: begin
                next_addr = word;
                phase     = ofsl_pkg::PH_CNT_HI;
            end
            ofsl_pkg::PH_CNT_LO: begin
                remaining = word;
                phase     = (word == 16'h0) ? ofsl_pkg::PH_HDR_HI : ofsl_pkg::PH_BODY_HI;
            end
            ofsl_pkg::PH_BODY_HI: begin
                if (rec_type == ofsl_pkg::RT_WORDS) begin
                    held_byte = b;
                    phase     = ofsl_pkg::PH_BODY_LO;
                end else begin
                    remaining = remaining - 16'd1;
                    if (remaining == 16'h0)
                        phase = ofsl_pkg::PH_HDR_HI;
                end
            end
            default: begin
                expected_results.push_back('{kind: ofsl_pkg::KIND_WRITE,
                                             addr: next_addr, data: word});
                next_addr = next_addr + 16'd1;
                remaining = remaining - 16'd1;
                phase     = (remaining == 16'h0) ? ofsl_pkg::PH_HDR_HI
                                                 : ofsl_pkg::PH_BODY_HI;
            end
        endcase
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task check_result(logic [1:0] kind, logic [15:0] addr, logic [15:0] data);
        t_loader_result want;
        if (expected_results.size() == 0) begin
            report($sformatf("unexpected result kind %0d addr %h data %h", kind, addr, data));
            return;
        end
        want = expected_results.pop_front();
        checked++;
        kind_seen[want.kind]++;
        if (kind !== want.kind)
            report($sformatf("result %0d kind %0d, want %0d", checked, kind, want.kind));
        if (addr !== want.addr)
            report($sformatf("result %0d address %h, want %h", checked, addr, want.addr));
        if (data !== want.data)
            report($sformatf("result %0d data %h, want %h", checked, data, want.data));
    endtask
endclass

module tb_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_operation;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [15:0] o_write_address;
    logic [15:0] o_write_data;

    loader_scoreboard board;
    t_file_request    stim_q[$];     // bytes of the file being sent
    int               burst_left  = 0;
    int               sent_count  = 0;
    int               file_count  = 0;
    int               noise_bytes = 0;  // bytes after a bad header, ignored by the loader
    int               random_count = 0;
    int               stall_mode  = 0;
    int               stall_left  = 0;

    object_file_stream_loader_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // file building helpers
    // ------------------------------------------------------------------

    function automatic void push_byte(logic [7:0] b);
        stim_q.push_back('{op: ofsl_pkg::OP_BYTE, b: b});
    endfunction

    // big-endian: high byte goes first
    function automatic void push_word(logic [15:0] w);
        push_byte(w[15:8]);
        push_byte(w[7:0]);
    endfunction

    // data byte rides along on eof but is ignored, so keep it random
    function automatic void push_eof();
        stim_q.push_back('{op: ofsl_pkg::OP_EOF, b: 8'($urandom_range(0, 255))});
    endfunction

    // one random object file: a mix of records, sometimes a bad header,
    // sometimes cut short, always closed by an end-of-file request
    function automatic void build_random_file();
        int          recs;
        int          pick;
        int          count;
        int          cut;
        logic [15:0] w;
        bit          broken;
        recs   = $urandom_range(1, 4);
        broken = 1'b0;
        for (int r = 0; r < recs && !broken; r++) begin
            pick  = $urandom_range(0, 19);
            // mostly short records, a few longer ones
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                : $urandom_range(0, 5);
            if (pick < 10) begin
                // code or data record: every body word is a write
                push_word(pick[0] ? ofsl_pkg::HDR_CODE : ofsl_pkg::HDR_DATA);
                if ($urandom_range(0, 3) == 0)
                    push_word(16'hFFFF - 16'($urandom_range(0, 3)));  // wraps through zero
                else
                    push_word(16'($urandom_range(0, 65535)));
                push_word(16'(count));
                for (int i = 0; i < count; i++)
                    push_word(16'($urandom_range(0, 65535)));
            end else if (pick < 13) begin
                // symbol record: address, byte count, bytes skipped
                push_word(ofsl_pkg::HDR_SYMBOL);
                push_word(16'($urandom_range(0, 65535)));
                push_word(16'(count * 2));
                for (int i = 0; i < count * 2; i++)
                    push_byte(8'($urandom_range(0, 255)));
            end else if (pick < 16) begin
                // file-name record; now and then a count past 255 so the
                // count high byte matters
                if ($urandom_range(0, 12) == 0)
                    count = $urandom_range(256, 300);
                push_word(ofsl_pkg::HDR_NAME);
                push_word(16'(count));
                for (int i = 0; i < count; i++)
                    push_byte(8'($urandom_range(0, 255)));
            end else if (pick < 18) begin
                // line-number record: three words skipped
                push_word(ofsl_pkg::HDR_LINE);
                for (int i = 0; i < 3; i++)
                    push_word(16'($urandom_range(0, 65535)));
            end else begin
                // unknown header, either a one-bit miss of a real one or random
                do begin
                    if ($urandom_range(0, 1) == 0)
                        w = ofsl_pkg::HDR_CODE ^ (16'h1 << $urandom_range(0, 15));
                    else
                        w = 16'($urandom_range(0, 65535));
                end while (w == ofsl_pkg::HDR_CODE || w == ofsl_pkg::HDR_DATA ||
                           w == ofsl_pkg::HDR_SYMBOL || w == ofsl_pkg::HDR_NAME ||
                           w == ofsl_pkg::HDR_LINE);
                push_word(w);
                broken = 1'b1;
                count  = $urandom_range(0, 6);
                for (int i = 0; i < count; i++)
                    push_byte(8'($urandom_range(0, 255)));
                noise_bytes += count;
            end
        end
        // cut the file short some of the time
        if (!broken && stim_q.size() > 1 && $urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, (stim_q.size() - 1 < 5) ? stim_q.size() - 1 : 5);
            repeat (cut) void'(stim_q.pop_back());
        end
        push_eof();
    endfunction

    // ------------------------------------------------------------------
    // sender: bursts of back-to-back requests with random gaps between
    // ------------------------------------------------------------------

    // entered and left just after a rising edge
    task automatic send_queued();
        t_file_request r;
        int            gap;
        while (stim_q.size() != 0) begin
            r = stim_q.pop_front();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            i_in_valid  <= 1'b1;
            i_operation <= r.op;
            i_data_byte <= r.b;
            // accepted on the first edge with stall low
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            board.predict_request(r.op, r.b);
            sent_count++;
        end
    endtask

    // hold off new requests until every owed result has come back;
    // the loop waits on the clock before it checks, so valid is never lowered and raised in one step
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // ------------------------------------------------------------------
    // receiver: stall pattern switches between randomly chosen modes
    // mode 0 never stalls, 1 and 2 stall lightly or half the time,
    // 3 stalls nearly always so results back up into the input side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // result monitor: values are those held just before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_kind, o_write_address, o_write_data);
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        board = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= ofsl_pkg::OP_BYTE;
        i_data_byte <= 8'h00;
        i_out_stall <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: code record at the top of memory, writes wrap to zero,
        // all-zero and all-one bytes
        push_word(ofsl_pkg::HDR_CODE);
        push_word(16'hFFFF);
        push_word(16'h0002);
        push_word(16'h0000);
        push_word(16'hFFFF);
        // data record with zero count ends at its count word
        push_word(ofsl_pkg::HDR_DATA);
        push_word(16'h1234);
        push_word(16'h0000);
        push_eof();                      // clean load
        push_byte(ofsl_pkg::HDR_LINE[15:8]);  // lone header high byte
        push_eof();                      // truncated
        push_word(16'h0000);             // unknown header
        push_byte(8'hA5);                // ignored after the error
        push_eof();                      // format error
        push_eof();                      // eof at idle after a reset of the parse
        send_queued();
        file_count += 4;

        // pause with nothing in flight before the random part
        drain_results();

        // random files until about 400 requests have gone in
        while (random_count < 400) begin
            noise_bytes = 0;
            build_random_file();
            random_count += stim_q.size() - noise_bytes;
            send_queued();
            file_count++;
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end

        // wait for the tail, then keep the clock running for stray results
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("summary: %0d requests over %0d files, %0d results checked",
                 sent_count, file_count, board.checked);
        $display("summary: %0d writes, %0d ok, %0d format errors, %0d truncated",
                 board.kind_seen[ofsl_pkg::KIND_WRITE],
                 board.kind_seen[ofsl_pkg::KIND_OK],
                 board.kind_seen[ofsl_pkg::KIND_FORMAT],
                 board.kind_seen[ofsl_pkg::KIND_TRUNCATED]);
        if (board.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", board.pending());
        $display("tb_top: errors");
        $finish;
    end

endmodule

[filelist.f]
sv/ofsl_pkg.sv
sv/ofsl_core.sv
sv/object_file_stream_loader_top.sv
bench/tb_top.sv
